// ===== hdl/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants for the multi-limb short divider.
// ----------------------------------------------------------------------------
package msd_pkg;

  // Fixed field and bus widths
  localparam int FIELD_W   = 64;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  // paddr bit that picks the register (registers sit at 8-byte steps)
  localparam int REG_SEL_BIT = 3;

  // Register indexes
  typedef enum logic {
    REG_DIVISOR = 1'b0,
    REG_RADIX   = 1'b1
  } reg_idx_t;

  // Reset values
  localparam logic [FIELD_W-1:0] DIVISOR_RST = 64'd1;
  localparam logic [FIELD_W-1:0] RADIX_RST   = 64'd10;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_DONE = 2'd3
  } msd_state_t;

endpackage

// ===== hdl/multi_limb_short_division.sv =====
// ----------------------------------------------------------------------------
// multi_limb_short_division
// Divides a multi-limb number, most significant limb first, by one limb.
// ----------------------------------------------------------------------------
// Channel   Dir  Ports            Contents
// in_       in   tdata/tuser/last digit / first_digit / last_digit
// out_      out  tdata/tlast      {running_remainder, quotient_digit} / is_last
// cfg_      in   APB, 64b data    0x0 divisor, 0x8 radix_base
//
// Each item runs through LIMB_WIDTH shift-add steps that form
// remainder*radix+digit, then 2*LIMB_WIDTH restoring steps that divide
// that double-width value.
// One item is in work at a time; the finished result sits in the output
// register so the next item can be taken while it waits.
// Reset: rst_n, synchronous; divisor 1, radix 10, carried remainder 0.
// A stalled output holds the sequencer in its last state until room frees up.
// ----------------------------------------------------------------------------
module multi_limb_short_division
  import msd_pkg::*;
#(
  parameter int LIMB_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [FIELD_W-1:0]    in_tdata,   // [63:0] digit
  input  logic                  in_tuser,   // [0] first_digit
  input  logic                  in_tlast,   // last_digit
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2*FIELD_W-1:0]  out_tdata,  // [63:0] quotient_digit,
                                            // [127:64] running_remainder
  output logic                  out_tlast,  // is_last
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int W     = LIMB_WIDTH;
  localparam int CNT_W = $clog2(2 * LIMB_WIDTH);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(LIMB_WIDTH - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(2 * LIMB_WIDTH - 1);

  // configuration registers
  logic [W-1:0] divisor_r, radix_r;
  // sequencer
  msd_state_t   state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  // datapath: rem_r is the multiplicand during MUL and the partial
  // remainder during DIV; after DIV it is the carried remainder
  logic [W-1:0]   rem_r, rem_nxt;
  logic [2*W-1:0] acc_r, acc_nxt;
  logic           last_r, last_nxt;
  // output register
  logic           out_valid_r;
  logic [W-1:0]   out_q_r, out_rem_r;
  logic           out_last_r;

  logic in_acc, load_out, cfg_wr;
  reg_idx_t reg_sel;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = reg_idx_t'(cfg_paddr[REG_SEL_BIT]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= DIVISOR_RST[W-1:0];
      radix_r   <= RADIX_RST[W-1:0];
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DIVISOR: begin
          // zero divisor writes are dropped
          if (cfg_pwdata[W-1:0] != '0) divisor_r <= cfg_pwdata[W-1:0];
        end
        REG_RADIX: radix_r <= cfg_pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DIVISOR: cfg_prdata = CFG_DATA_W'(divisor_r);
      REG_RADIX:   cfg_prdata = CFG_DATA_W'(radix_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_MUL;
      ST_MUL:  if (cnt_r == MUL_LAST) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == DIV_LAST) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_DONE: load_out  = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign in_acc = in_tvalid & in_tready;

  // ---------------- datapath ----------------
  logic [W:0] mul_sum;
  logic [W:0] div_shift;
  logic [W:0] div_diff;
  logic       div_ge;

  always_comb begin
    // multiply-add, LSB of radix first: acc = {hi, radix bits left}
    mul_sum   = {1'b0, acc_r[2*W-1:W]} + (acc_r[0] ? {1'b0, rem_r} : '0);
    // restoring division, dividend bits leave acc at the top
    div_shift = {rem_r, acc_r[2*W-1]};
    div_diff  = div_shift - {1'b0, divisor_r};
    div_ge    = (div_shift >= {1'b0, divisor_r});

    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rem_nxt  = in_tuser ? '0 : rem_r;
          acc_nxt  = {in_tdata[W-1:0], radix_r};
          cnt_nxt  = '0;
          last_nxt = in_tlast;
        end
      end
      ST_MUL: begin
        acc_nxt = {mul_sum, acc_r[W-1:1]};
        if (cnt_r == MUL_LAST) begin
          rem_nxt = '0;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? div_diff[W-1:0] : div_shift[W-1:0];
        acc_nxt = {acc_r[2*W-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      if (load_out)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    last_r <= last_nxt;
    if (load_out) begin
      out_q_r    <= acc_r[W-1:0];
      out_rem_r  <= rem_r;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {FIELD_W'(out_rem_r), FIELD_W'(out_q_r)};
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/msd_checker.sv =====
// ----------------------------------------------------------------------------
// msd_checker
// Port-level checks for the multi-limb short divider.
// ----------------------------------------------------------------------------
module msd_checker
  import msd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [2*FIELD_W-1:0]  out_tdata,
  input logic                  out_tlast,
  input logic                  cfg_psel,
  input logic                  cfg_pready
);

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("not idle after reset");

  // an accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item taken while one is in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result changed");

  // the config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("pready low");

endmodule

bind multi_limb_short_division msd_checker u_msd_checker (.*);
